// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low asynchronous reset that disables it.
`define GBE_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gpio bank assertion failed");

// Same, on the house clock and reset names.
`define GBE_ASSERT(lbl, prop) `GBE_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/gbe_pkg.sv =====
package gbe_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned OFF_W         = 6;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned FSEL_W        = 3;
  localparam int unsigned PINS_PER_FSEL = 10;
  localparam int unsigned FSEL_WORDS    = 4;
  localparam int unsigned FSEL_BITS     = FSEL_W * PINS_PER_FSEL;
  localparam int unsigned MAX_PINS      = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PULL_OFF  = 2'd0,
    PULL_DOWN = 2'd1,
    PULL_UP   = 2'd2,
    PULL_RSVD = 2'd3
  } pull_e;

  // Bus word offsets.
  localparam logic [OFF_W-1:0] OFF_FSEL0  = 6'd0;
  localparam logic [OFF_W-1:0] OFF_FSEL1  = 6'd1;
  localparam logic [OFF_W-1:0] OFF_FSEL2  = 6'd2;
  localparam logic [OFF_W-1:0] OFF_FSEL3  = 6'd3;
  localparam logic [OFF_W-1:0] OFF_SET    = 6'd7;
  localparam logic [OFF_W-1:0] OFF_CLR    = 6'd10;
  localparam logic [OFF_W-1:0] OFF_LEV    = 6'd13;
  localparam logic [OFF_W-1:0] OFF_EDS    = 6'd16;
  localparam logic [OFF_W-1:0] OFF_REN    = 6'd19;
  localparam logic [OFF_W-1:0] OFF_FEN    = 6'd22;
  localparam logic [OFF_W-1:0] OFF_PUD    = 6'd37;
  localparam logic [OFF_W-1:0] OFF_PUDCLK = 6'd38;

  localparam logic [FSEL_W-1:0] FUNC_OUTPUT = 3'b001;

  // One accepted transfer, decoded, as every lane sees it.
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              tick;
    logic [OFF_W-1:0]  offset;
    logic [DATA_W-1:0] wdata;
  } cmd_t;

  // State of one pin lane.
  typedef struct packed {
    logic [FSEL_W-1:0] fsel;
    logic              latch;
    logic              ren;
    logic              fen;
    logic              evt;
    logic              newest;
    logic              pclk;
    logic              pu;
    logic              pd;
  } lane_t;

  // Words assembled from all lanes.
  typedef struct packed {
    logic [DATA_W-1:0] rd_word;
    logic [DATA_W-1:0] drive;
    logic [DATA_W-1:0] oe;
    logic              irq;
    logic [DATA_W-1:0] pu;
    logic [DATA_W-1:0] pd;
  } merge_t;

endpackage

// ===== rtl/gbe_if.sv =====
interface gbe_in_if;
  logic                          valid;
  logic                          ready;
  logic [gbe_pkg::KIND_W-1:0]    kind;
  logic [gbe_pkg::OFF_W-1:0]     reg_offset;
  logic [gbe_pkg::DATA_W-1:0]    write_data;
  logic [gbe_pkg::DATA_W-1:0]    pin_levels;

  modport source (output valid, kind, reg_offset, write_data, pin_levels, input ready);
  modport sink   (input valid, kind, reg_offset, write_data, pin_levels, output ready);
endinterface

interface gbe_out_if;
  logic                          valid;
  logic                          ready;
  logic [gbe_pkg::DATA_W-1:0]    read_data;
  logic [gbe_pkg::DATA_W-1:0]    pin_drive;
  logic [gbe_pkg::DATA_W-1:0]    pin_output_enable;
  logic                          irq;
  logic [gbe_pkg::DATA_W-1:0]    pull_up_mask;
  logic [gbe_pkg::DATA_W-1:0]    pull_down_mask;

  modport source (output valid, read_data, pin_drive, pin_output_enable, irq,
                  pull_up_mask, pull_down_mask, input ready);
  modport sink   (input valid, read_data, pin_drive, pin_output_enable, irq,
                  pull_up_mask, pull_down_mask, output ready);
endinterface

// ===== rtl/gbe_lane.sv =====
module gbe_lane #(
  parameter int unsigned LANE = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gbe_pkg::cmd_t   cmd_i,
  input  logic            level_i,
  input  gbe_pkg::pull_e  pull_mode_i,
  output gbe_pkg::lane_t  lane_o
);

  localparam int unsigned FselWord = LANE / gbe_pkg::PINS_PER_FSEL;
  localparam int unsigned FselLsb  = gbe_pkg::FSEL_W * (LANE % gbe_pkg::PINS_PER_FSEL);
  localparam logic [gbe_pkg::OFF_W-1:0] FselOff = FselWord[gbe_pkg::OFF_W-1:0];

  logic [gbe_pkg::FSEL_W-1:0] fsel_q, fsel_d;
  logic latch_q, latch_d, ren_q, ren_d, fen_q, fen_d, evt_q, evt_d;
  logic newest_q, newest_d, older_q, older_d, pclk_q, pclk_d;
  logic pu_q, pu_d, pd_q, pd_d;
  logic wbit, rise, fall;

  assign wbit = cmd_i.wdata[LANE];
  assign rise = !older_q && newest_q && level_i;
  assign fall = older_q && !newest_q && !level_i;

  always_comb begin
    fsel_d   = fsel_q;
    latch_d  = latch_q;
    ren_d    = ren_q;
    fen_d    = fen_q;
    evt_d    = evt_q;
    newest_d = newest_q;
    older_d  = older_q;
    pclk_d   = pclk_q;
    if (cmd_i.wr) begin
      if (cmd_i.offset == FselOff) fsel_d = cmd_i.wdata[FselLsb +: gbe_pkg::FSEL_W];
      if (cmd_i.offset == gbe_pkg::OFF_SET && wbit) latch_d = 1'b1;
      if (cmd_i.offset == gbe_pkg::OFF_CLR && wbit) latch_d = 1'b0;
      if (cmd_i.offset == gbe_pkg::OFF_EDS && wbit) evt_d = 1'b0;
      if (cmd_i.offset == gbe_pkg::OFF_REN) ren_d = wbit;
      if (cmd_i.offset == gbe_pkg::OFF_FEN) fen_d = wbit;
      if (cmd_i.offset == gbe_pkg::OFF_PUDCLK) pclk_d = wbit;
    end
    if (cmd_i.tick) begin
      evt_d    = evt_q || (rise && ren_q) || (fall && fen_q);
      older_d  = newest_q;
      newest_d = level_i;
    end
    // Pull latch follows the clock bit as it stands after the write.
    pu_d = pu_q;
    pd_d = pd_q;
    if (pclk_d) begin
      unique case (pull_mode_i)
        gbe_pkg::PULL_OFF:  begin pu_d = 1'b0; pd_d = 1'b0; end
        gbe_pkg::PULL_DOWN: begin pu_d = 1'b0; pd_d = 1'b1; end
        gbe_pkg::PULL_UP:   begin pu_d = 1'b1; pd_d = 1'b0; end
        default:            begin pu_d = pu_q; pd_d = pd_q; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q   <= '0;
      latch_q  <= 1'b0;
      ren_q    <= 1'b0;
      fen_q    <= 1'b0;
      evt_q    <= 1'b0;
      newest_q <= 1'b0;
      older_q  <= 1'b0;
      pclk_q   <= 1'b0;
      pu_q     <= 1'b0;
      pd_q     <= 1'b0;
    end else begin
      fsel_q   <= fsel_d;
      latch_q  <= latch_d;
      ren_q    <= ren_d;
      fen_q    <= fen_d;
      evt_q    <= evt_d;
      newest_q <= newest_d;
      older_q  <= older_d;
      pclk_q   <= pclk_d;
      pu_q     <= pu_d;
      pd_q     <= pd_d;
    end
  end

  assign lane_o = '{fsel: fsel_q, latch: latch_q, ren: ren_q, fen: fen_q, evt: evt_q,
                    newest: newest_q, pclk: pclk_q, pu: pu_q, pd: pd_q};

endmodule

// ===== rtl/gbe_merge.sv =====
module gbe_merge #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  gbe_pkg::lane_t             lanes_i [PIN_COUNT],
  input  logic [gbe_pkg::OFF_W-1:0]  offset_i,
  input  gbe_pkg::pull_e             pull_mode_i,
  output gbe_pkg::merge_t            merge_o
);

  logic [gbe_pkg::FSEL_WORDS*gbe_pkg::FSEL_BITS-1:0] fsel_flat;
  logic [gbe_pkg::DATA_W-1:0] lev_w, eds_w, ren_w, fen_w, pclk_w;
  logic [gbe_pkg::DATA_W-1:0] drive_w, oe_w, pu_w, pd_w, rd_w;

  always_comb begin
    fsel_flat = '0;
    lev_w     = '0;
    eds_w     = '0;
    ren_w     = '0;
    fen_w     = '0;
    pclk_w    = '0;
    drive_w   = '0;
    oe_w      = '0;
    pu_w      = '0;
    pd_w      = '0;
    for (int p = 0; p < PIN_COUNT; p++) begin
      fsel_flat[gbe_pkg::FSEL_W*p +: gbe_pkg::FSEL_W] = lanes_i[p].fsel;
      lev_w[p]   = lanes_i[p].newest;
      eds_w[p]   = lanes_i[p].evt;
      ren_w[p]   = lanes_i[p].ren;
      fen_w[p]   = lanes_i[p].fen;
      pclk_w[p]  = lanes_i[p].pclk;
      drive_w[p] = lanes_i[p].latch;
      oe_w[p]    = (lanes_i[p].fsel == gbe_pkg::FUNC_OUTPUT);
      pu_w[p]    = lanes_i[p].pu;
      pd_w[p]    = lanes_i[p].pd;
    end
  end

  // Read mux; unmapped and write-only words read zero.
  always_comb begin
    unique case (offset_i)
      gbe_pkg::OFF_FSEL0:  rd_w = 32'(fsel_flat[0*gbe_pkg::FSEL_BITS +: gbe_pkg::FSEL_BITS]);
      gbe_pkg::OFF_FSEL1:  rd_w = 32'(fsel_flat[1*gbe_pkg::FSEL_BITS +: gbe_pkg::FSEL_BITS]);
      gbe_pkg::OFF_FSEL2:  rd_w = 32'(fsel_flat[2*gbe_pkg::FSEL_BITS +: gbe_pkg::FSEL_BITS]);
      gbe_pkg::OFF_FSEL3:  rd_w = 32'(fsel_flat[3*gbe_pkg::FSEL_BITS +: gbe_pkg::FSEL_BITS]);
      gbe_pkg::OFF_LEV:    rd_w = lev_w;
      gbe_pkg::OFF_EDS:    rd_w = eds_w;
      gbe_pkg::OFF_REN:    rd_w = ren_w;
      gbe_pkg::OFF_FEN:    rd_w = fen_w;
      gbe_pkg::OFF_PUD:    rd_w = 32'(pull_mode_i);
      gbe_pkg::OFF_PUDCLK: rd_w = pclk_w;
      default:             rd_w = '0;
    endcase
  end

  assign merge_o = '{rd_word: rd_w, drive: drive_w, oe: oe_w, irq: |eds_w,
                     pu: pu_w, pd: pd_w};

endmodule

// ===== rtl/gpio_bank_with_edge_events.sv =====
// The result of a transfer is registered and shown in the cycle after it is accepted.
// Throughput: one transfer per cycle; a held result does not block the next transfer
//   unless it is still waiting when that transfer arrives.
// Reset: asynchronous, active low; clears every pin lane, the pull mode and the
//   result valid flag. No clearing pass.
module gpio_bank_with_edge_events #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gbe_in_if.sink      in_i,
  gbe_out_if.source   out_o
);

  // Handshake: a new transfer enters when the result slot is empty or is being
  // drained in the same cycle. All pin state lives in the lanes and only moves
  // on an accepted transfer, so the live lane words stay valid as the result
  // for as long as the slot holds.
  logic accept;
  logic out_valid_q, out_valid_d;
  logic [gbe_pkg::DATA_W-1:0] rdata_q, rdata_d;

  gbe_pkg::kind_e  kind;
  gbe_pkg::cmd_t   cmd;
  gbe_pkg::pull_e  pull_mode_q, pull_mode_d;
  gbe_pkg::lane_t  lanes [PIN_COUNT];
  gbe_pkg::merge_t merged;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign kind       = gbe_pkg::kind_e'(in_i.kind);

  // Decode the transfer once; every lane picks out its own bits.
  always_comb begin
    cmd.rd     = 1'b0;
    cmd.wr     = 1'b0;
    cmd.tick   = 1'b0;
    cmd.offset = in_i.reg_offset;
    cmd.wdata  = in_i.write_data;
    if (accept) begin
      unique case (kind)
        gbe_pkg::KIND_READ:  cmd.rd   = 1'b1;
        gbe_pkg::KIND_WRITE: cmd.wr   = 1'b1;
        gbe_pkg::KIND_TICK:  cmd.tick = 1'b1;
        default:             cmd.rd   = 1'b0;
      endcase
    end
  end

  // Pull mode is shared by all pins; lanes see the value after this transfer's
  // write so the pull latch acts on the freshly written mode.
  always_comb begin
    pull_mode_d = pull_mode_q;
    if (cmd.wr && cmd.offset == gbe_pkg::OFF_PUD) begin
      pull_mode_d = gbe_pkg::pull_e'(cmd.wdata[1:0]);
    end
  end

  for (genvar g = 0; g < PIN_COUNT; g++) begin : g_lane
    gbe_lane #(
      .LANE (g)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .level_i     (in_i.pin_levels[g]),
      .pull_mode_i (pull_mode_d),
      .lane_o      (lanes[g])
    );
  end

  // Merge the lanes: read word from pre-transfer state, status words from live state.
  gbe_merge #(
    .PIN_COUNT (PIN_COUNT)
  ) u_merge (
    .lanes_i     (lanes),
    .offset_i    (in_i.reg_offset),
    .pull_mode_i (pull_mode_q),
    .merge_o     (merged)
  );

  // Capture read data on accept; anything but a read returns zero.
  assign rdata_d = cmd.rd ? merged.rd_word : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pull_mode_q <= gbe_pkg::PULL_OFF;
    end else begin
      out_valid_q <= out_valid_d;
      pull_mode_q <= pull_mode_d;
    end
  end

  // Payload register: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= rdata_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.read_data         = rdata_q;
  assign out_o.pin_drive         = merged.drive;
  assign out_o.pin_output_enable = merged.oe;
  assign out_o.irq               = merged.irq;
  assign out_o.pull_up_mask      = merged.pu;
  assign out_o.pull_down_mask    = merged.pd;

endmodule

// ===== rtl/gbe_checker.sv =====
`include "assert_macros.svh"

module gbe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [gbe_pkg::KIND_W-1:0]    in_kind_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [gbe_pkg::DATA_W-1:0]    out_read_data_i,
  input logic                          out_irq_i,
  input logic [gbe_pkg::DATA_W-1:0]    out_pull_up_i,
  input logic [gbe_pkg::DATA_W-1:0]    out_pull_down_i
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  `GBE_ASSERT(a_hold_stalled, out_valid_i && !out_ready_i |=> $stable(out_read_data_i))
  `GBE_ASSERT(a_accept_gives_result, in_xfer |=> out_valid_i)
  `GBE_ASSERT(a_nonread_zero, in_xfer && in_kind_i != gbe_pkg::KIND_READ |=> out_read_data_i == '0)
  `GBE_ASSERT(a_pull_exclusive, (out_pull_up_i & out_pull_down_i) == '0)
  `GBE_ASSERT(a_irq_moves_on_transfer, !$stable(out_irq_i) |-> $past(in_xfer))

endmodule

bind gpio_bank_with_edge_events gbe_checker u_gbe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_kind_i       (in_i.kind),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_read_data_i (out_o.read_data),
  .out_irq_i       (out_o.irq),
  .out_pull_up_i   (out_o.pull_up_mask),
  .out_pull_down_i (out_o.pull_down_mask)
);
